>>> src/binned_histogram_engine_assert.svh
// Assertion macros for the binned histogram engine.
// Used by binned_histogram_engine.sv; expects clk_i and rst_ni in scope.
`ifndef BINNED_HISTOGRAM_ENGINE_ASSERT_SVH
`define BINNED_HISTOGRAM_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BHE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BHE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bhe_pkg.sv
// Shared constants, types and codes of the binned histogram engine.
// No dependencies; compiled first.
`default_nettype none

package bhe_pkg;

  localparam int MAX_BINS = 1024;
  localparam int BIN_W    = $clog2(MAX_BINS);
  localparam int CNT_W    = $clog2(MAX_BINS + 1);

  localparam int REQ_W    = 3;
  localparam int SAMPLE_W = 24;
  localparam int IDX_W    = 10;
  localparam int VALUE_W  = 32;
  localparam int DATA_W   = 32;

  localparam int RS_W     = 24;
  localparam int BPU_W    = 28;
  localparam int BIU_W    = 11;
  localparam int CFG_W    = 28;
  localparam int CFG_IDX_W = 2;

  // Q16.8 times Q12.16 gives 24 fraction bits
  localparam int FRAC_SH  = 24;
  localparam int PROD_W   = SAMPLE_W + BPU_W;
  localparam int BINP_W   = PROD_W - FRAC_SH;
  localparam int SPLIT_W  = BPU_W / 2;
  localparam int PP_LO_W  = SAMPLE_W + SPLIT_W;
  localparam int PP_HI_W  = SAMPLE_W + (BPU_W - SPLIT_W);

  localparam logic [RS_W-1:0]  RS_RST  = RS_W'(0);
  localparam logic [BPU_W-1:0] BPU_RST = BPU_W'(65536);
  localparam logic [BIU_W-1:0] BIU_RST = BIU_W'(1024);

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(MAX_BINS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_START   = 2'd0,
    CFG_BINS_PER_UNIT = 2'd1,
    CFG_BINS_IN_USE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_FILL  = 3'd0,
    REQ_CLEAR = 3'd1,
    REQ_READ  = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_SUM   = 3'd4,
    REQ_TOTAL = 3'd5
  } req_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MAP,
    ST_RD,
    ST_RDATA,
    ST_WR,
    ST_CLR,
    ST_SUM,
    ST_SUM_TAIL,
    ST_EMIT
  } state_e;

  // Bin mapper result, valid for one cycle
  typedef struct packed {
    logic             valid;
    logic             oor;
    logic [BIN_W-1:0] bin;
  } map_res_t;

endpackage

`default_nettype wire

>>> src/bhe_ifs.sv
// Request and response channel interfaces of the binned histogram engine.
// Depends on bhe_pkg.
`default_nettype none

interface bhe_req_if;
  import bhe_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [SAMPLE_W-1:0] sample;
  logic [IDX_W-1:0]    bin_index;
  logic [VALUE_W-1:0]  bin_value;

  modport source (output valid, req_type, sample, bin_index, bin_value, input ready);
  modport sink   (input valid, req_type, sample, bin_index, bin_value, output ready);
endinterface

interface bhe_rsp_if;
  import bhe_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_data;
  logic              status;

  modport source (output valid, result_data, status, input ready);
  modport sink   (input valid, result_data, status, output ready);
endinterface

`default_nettype wire

>>> src/bhe_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bhe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/bhe_bin_map.sv
// Two-stage sample-to-bin mapper: offset and split multiply, then sum and range check.
// Depends on bhe_pkg.
`default_nettype none

module bhe_bin_map (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [bhe_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic [bhe_pkg::RS_W-1:0]     range_start_i,
  input  wire logic [bhe_pkg::BPU_W-1:0]    bins_per_unit_i,
  input  wire logic [bhe_pkg::CNT_W-1:0]    n_eff_i,
  output bhe_pkg::map_res_t                 res_o
);
  import bhe_pkg::*;

  logic                v1_q;
  logic                below_q, below_d;
  logic [PP_LO_W-1:0]  pl_q, pl_d;
  logic [PP_HI_W-1:0]  ph_q, ph_d;
  logic [SAMPLE_W-1:0] diff;
  logic [PROD_W-1:0]   prod;
  logic [BINP_W-1:0]   binp;
  map_res_t            res_q, res_d;

  // stage 1: offset, two narrow partial products
  always_comb begin
    below_d = sample_i < SAMPLE_W'(range_start_i);
    diff    = sample_i - SAMPLE_W'(range_start_i);
    pl_d    = PP_LO_W'(diff) * PP_LO_W'(bins_per_unit_i[SPLIT_W-1:0]);
    ph_d    = PP_HI_W'(diff) * PP_HI_W'(bins_per_unit_i[BPU_W-1:SPLIT_W]);
  end

  // stage 2: recombine, floor by shift, range check
  always_comb begin
    prod       = PROD_W'(pl_q) + (PROD_W'(ph_q) << SPLIT_W);
    binp       = prod[PROD_W-1:FRAC_SH];
    res_d.valid = v1_q;
    res_d.oor   = below_q || (binp >= BINP_W'(n_eff_i));
    res_d.bin   = binp[BIN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      res_q <= '0;
    end else begin
      v1_q  <= start_i;
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      below_q <= below_d;
      pl_q    <= pl_d;
      ph_q    <= ph_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> src/binned_histogram_engine.sv
// Binned histogram engine: top level, request sequencer around the bin counter RAM.
// Depends on bhe_pkg, bhe_ifs, bhe_ram, bhe_bin_map and binned_histogram_engine_assert.svh.
//
// Usage
// - req_i carries one request (fill, clear, read, write, sum from threshold, total);
//   rsp_o returns exactly one response per request, in order.
// - Requests are served one at a time. Total sums bins 0 to n - 1, sum from threshold
//   sums from the threshold's bin to n - 1, and clear zeroes all MAX_BINS bins, with
//   n = min(bins_in_use, MAX_BINS).
//   Fill is a read-modify-write and clear, sum and total sweep one entry per cycle, all through
//   the single counter RAM port pair, so the sweeps set the cost of clear, sum and total.
// - Out-of-range fills, reads, writes and thresholds finish early with status 1.
// - After reset the block sweeps all MAX_BINS (1024) RAM entries to zero,
//   holding req_i.ready low; configuration writes are taken throughout.
// - The response sits in an output register. A stalled receiver holds it there;
//   the next request is still accepted and runs, and waits in its final state
//   only if the previous response has not yet been taken.
// - Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i, by the user only while
//   the block is idle, which the block does not enforce; unknown indices are ignored.
`default_nettype none
`include "binned_histogram_engine_assert.svh"

module binned_histogram_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bhe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bhe_pkg::CFG_W-1:0]     cfg_data_i,
  bhe_req_if.sink                            req_i,
  bhe_rsp_if.source                          rsp_o
);
  import bhe_pkg::*;

  // configuration
  logic [RS_W-1:0]  range_start_q;
  logic [BPU_W-1:0] bins_per_unit_q;
  logic [BIU_W-1:0] bins_in_use_q;
  logic [CNT_W-1:0] n_eff;

  // sequencer
  state_e              state_q, state_d;
  logic [REQ_W-1:0]    req_q, req_d;
  logic [BIN_W-1:0]    addr_q, addr_d;
  logic [BIN_W-1:0]    ptr_q, ptr_d;
  logic [VALUE_W-1:0]  value_q, value_d;
  logic [DATA_W-1:0]   acc_q, acc_d;
  logic                pend_q, pend_d;
  logic [DATA_W-1:0]   res_data_q, res_data_d;
  logic                res_status_q, res_status_d;
  logic                last_sum;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_status_q, out_status_d;
  logic              out_load;

  // RAM and mapper
  logic              mem_we, mem_re;
  logic [BIN_W-1:0]  mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;
  logic              map_start;
  map_res_t          map_res;

  always_comb begin
    if (32'(bins_in_use_q) > 32'(MAX_BINS)) begin
      n_eff = CNT_W'(MAX_BINS);
    end else begin
      n_eff = CNT_W'(bins_in_use_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q   <= RS_RST;
      bins_per_unit_q <= BPU_RST;
      bins_in_use_q   <= BIU_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RANGE_START:   range_start_q   <= cfg_data_i[RS_W-1:0];
        CFG_BINS_PER_UNIT: bins_per_unit_q <= cfg_data_i[BPU_W-1:0];
        CFG_BINS_IN_USE:   bins_in_use_q   <= cfg_data_i[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  bhe_bin_map u_map (
    .clk_i,
    .rst_ni,
    .start_i         (map_start),
    .sample_i        (req_i.sample),
    .range_start_i   (range_start_q),
    .bins_per_unit_i (bins_per_unit_q),
    .n_eff_i         (n_eff),
    .res_o           (map_res)
  );

  bhe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_BINS)
  ) u_ram (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign last_sum    = ({1'b0, ptr_q} == (BIN_W + 1)'(n_eff - CNT_W'(1)));
  assign out_load    = (state_q == ST_EMIT) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    addr_d       = addr_q;
    ptr_d        = ptr_q;
    value_d      = value_q;
    acc_d        = acc_q;
    pend_d       = 1'b0;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = ptr_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = addr_q;
    map_start    = 1'b0;

    // sweep reads land in the next cycle
    if (pend_q) begin
      acc_d = acc_q + mem_rdata;
    end

    case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        if (ptr_q == LAST_BIN) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + BIN_W'(1);
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          req_d        = req_i.req_type;
          value_d      = req_i.bin_value;
          addr_d       = BIN_W'(req_i.bin_index);
          res_data_d   = '0;
          res_status_d = 1'b0;
          acc_d        = '0;
          ptr_d        = '0;
          case (req_i.req_type)
            REQ_FILL, REQ_SUM: begin
              map_start = 1'b1;
              state_d   = ST_MAP;
            end
            REQ_CLEAR: state_d = ST_CLR;
            REQ_READ, REQ_WRITE: begin
              if (32'(req_i.bin_index) < 32'(n_eff)) begin
                state_d = (req_i.req_type == REQ_READ) ? ST_RD : ST_WR;
              end else begin
                res_status_d = 1'b1;
                state_d      = ST_EMIT;
              end
            end
            REQ_TOTAL: state_d = (n_eff == '0) ? ST_EMIT : ST_SUM;
            default:   state_d = ST_EMIT;
          endcase
        end
      end
      ST_MAP: begin
        if (map_res.valid) begin
          if (map_res.oor) begin
            res_status_d = 1'b1;
            state_d      = ST_EMIT;
          end else if (req_q == REQ_FILL) begin
            addr_d  = map_res.bin;
            state_d = ST_RD;
          end else begin
            ptr_d   = map_res.bin;
            state_d = ST_SUM;
          end
        end
      end
      ST_RD: begin
        mem_re  = 1'b1;
        state_d = ST_RDATA;
      end
      ST_RDATA: begin
        if (req_q == REQ_FILL) begin
          mem_we    = 1'b1;
          mem_waddr = addr_q;
          mem_wdata = mem_rdata + DATA_W'(1);
        end else begin
          res_data_d = mem_rdata;
        end
        state_d = ST_EMIT;
      end
      ST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = value_q;
        state_d   = ST_EMIT;
      end
      ST_CLR: begin
        mem_we = 1'b1;
        if (ptr_q == LAST_BIN) begin
          state_d = ST_EMIT;
        end else begin
          ptr_d = ptr_q + BIN_W'(1);
        end
      end
      ST_SUM: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_q;
        pend_d    = 1'b1;
        if (last_sum) begin
          state_d = ST_SUM_TAIL;
        end else begin
          ptr_d = ptr_q + BIN_W'(1);
        end
      end
      ST_SUM_TAIL: begin
        res_data_d = acc_q + mem_rdata;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_data_d   = res_data_q;
      out_status_d = res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    addr_q       <= addr_d;
    value_q      <= value_d;
    acc_q        <= acc_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_data = out_data_q;
  assign rsp_o.status      = out_status_q;

  // checks
  `BHE_ASSERT_NXT(a_accept_leaves_idle, req_i.valid && req_i.ready, state_q != ST_IDLE, "request accepted but sequencer stayed idle")
  `BHE_ASSERT_IMP(a_we_states, mem_we, state_q == ST_INIT || state_q == ST_CLR || state_q == ST_WR || state_q == ST_RDATA, "RAM write outside a writing state")
  `BHE_ASSERT_IMP(a_sum_in_range, state_q == ST_SUM, (BIN_W + 1)'(ptr_q) < (BIN_W + 1)'(n_eff), "sum sweep past the bins in use")
  `BHE_ASSERT_IMP(a_map_when_waiting, map_res.valid, state_q == ST_MAP, "bin mapper result with no request waiting")

endmodule

`default_nettype wire
